>>> sv/wgm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types, codes and helpers of the wildcard glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

	localparam int PATTERN_MAX_DEF = 64;
	localparam int CHAR_W = 16;

	localparam logic [CHAR_W-1:0] CH_QUESTION = 16'h003F;
	localparam logic [CHAR_W-1:0] CH_STAR     = 16'h002A;
	localparam logic [CHAR_W-1:0] CH_LOWER_A  = 16'h0061;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z  = 16'h007A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 16'h0020;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEXT   = 2'd2,
		OP_END    = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t           opcode;
		logic [CHAR_W-1:0] char_code;
	} item_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} result_t;

	typedef struct packed {
		logic              clear;
		logic              append;
		logic [CHAR_W-1:0] char_code;
	} pat_cmd_t;

	typedef struct packed {
		logic advance;
		logic restart;
	} nfa_cmd_t;

	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			r = c - CASE_OFFSET;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> sv/wildcard_glob_matcher.sv
`default_nettype none
// An end-of-text transaction passes the input register, then its verdict is registered in the result register.
// Throughput: one transaction per cycle unless stalled; one input register and one result register.
// A result waiting to be taken stalls the next end-of-text transaction and every transaction behind it.
// Reset (arst_n low): pattern empty, overflow flag clear, text state restarted.
// Pattern character storage is not reset and is valid only once written.
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Case-insensitive glob matcher for '*' and '?' over a loaded pattern.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher #(
	parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire wgm_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output wgm_pkg::result_t      result
);

	localparam int LW = $clog2(PATTERN_MAX + 1);

	logic                   valid_s1;
	wgm_pkg::item_t         item_s1;
	logic                   go;
	logic                   result_valid_q;
	wgm_pkg::result_t       result_q;
	wgm_pkg::pat_cmd_t      pat_cmd;
	wgm_pkg::nfa_cmd_t      nfa_cmd;
	logic [LW-1:0]          length;
	logic                   overflow;
	logic [PATTERN_MAX:0]   prop;
	logic [PATTERN_MAX-1:0] stay;
	logic [PATTERN_MAX-1:0] step;
	logic                   matched;

	assign go = valid_s1 && ((item_s1.opcode != wgm_pkg::OP_END)
		|| !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		pat_cmd.clear     = go && (item_s1.opcode == wgm_pkg::OP_CLEAR);
		pat_cmd.append    = go && (item_s1.opcode == wgm_pkg::OP_APPEND);
		pat_cmd.char_code = item_s1.char_code;
		nfa_cmd.advance   = go && (item_s1.opcode == wgm_pkg::OP_TEXT);
		nfa_cmd.restart   = go && (item_s1.opcode != wgm_pkg::OP_TEXT);
	end

	wgm_pattern_store #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (pat_cmd),
		.text_char(item_s1.char_code),
		.length   (length),
		.overflow (overflow),
		.prop     (prop),
		.stay     (stay),
		.step     (step)
	);

	wgm_nfa #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_nfa (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (nfa_cmd),
		.prop   (prop),
		.stay   (stay),
		.step   (step),
		.length (length),
		.matched(matched)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (go && (item_s1.opcode == wgm_pkg::OP_END)) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && (item_s1.opcode == wgm_pkg::OP_END)) begin
			result_q.matched          <= matched;
			result_q.pattern_overflow <= overflow;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

>>> sv/wgm_pattern_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wgm_pattern_store
// Pattern cells with length and overflow tracking. Each cell compares its
// stored character against the current text character in parallel.
// ----------------------------------------------------------------------------
module wgm_pattern_store #(
	parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF,
	localparam int LW = $clog2(PATTERN_MAX + 1),
	localparam int IW = $clog2(PATTERN_MAX)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire wgm_pkg::pat_cmd_t           cmd,
	input  wire logic [wgm_pkg::CHAR_W-1:0]  text_char,
	output logic      [LW-1:0]               length,
	output logic                             overflow,
	output logic      [PATTERN_MAX:0]        prop,
	output logic      [PATTERN_MAX-1:0]      stay,
	output logic      [PATTERN_MAX-1:0]      step
);

	logic [wgm_pkg::CHAR_W-1:0] char_q [PATTERN_MAX];
	logic [PATTERN_MAX-1:0]     star_q;
	logic [PATTERN_MAX-1:0]     any_q;
	logic [LW-1:0]              length_q;
	logic                       overflow_q;
	logic                       full;
	logic [wgm_pkg::CHAR_W-1:0] text_fold;

	assign full      = (length_q == LW'(PATTERN_MAX));
	assign text_fold = wgm_pkg::fold_case(text_char);
	assign length    = length_q;
	assign overflow  = overflow_q;
	assign prop[0]   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q   <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.clear) begin
			length_q   <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.append) begin
			if (full) begin
				overflow_q <= 1'b1;
			end else begin
				length_q <= length_q + LW'(1);
			end
		end
	end

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		logic wr;
		logic used;

		assign wr   = cmd.append && !full && (length_q[IW-1:0] == IW'(i));
		assign used = (LW'(i) < length_q);

		always_ff @(posedge clk) begin
			if (wr) begin
				char_q[i] <= wgm_pkg::fold_case(cmd.char_code);
				star_q[i] <= (cmd.char_code == wgm_pkg::CH_STAR);
				any_q[i]  <= (cmd.char_code == wgm_pkg::CH_QUESTION);
			end
		end

		assign prop[i+1] = used && star_q[i];
		assign stay[i]   = used && star_q[i];
		assign step[i]   = used && !star_q[i] && (any_q[i] || (char_q[i] == text_fold));
	end

endmodule
`default_nettype wire

>>> sv/wgm_nfa.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wgm_nfa
// Live position vector. Star closure is done as a carry chain through one
// wide add, then all positions advance in parallel on a text character.
// ----------------------------------------------------------------------------
module wgm_nfa #(
	parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF,
	localparam int LW = $clog2(PATTERN_MAX + 1),
	localparam int W  = PATTERN_MAX + 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire wgm_pkg::nfa_cmd_t      cmd,
	input  wire logic [W-1:0]           prop,
	input  wire logic [PATTERN_MAX-1:0] stay,
	input  wire logic [PATTERN_MAX-1:0] step,
	input  wire logic [LW-1:0]          length,
	output logic                        matched
);

	logic [W-1:0] live_q;
	logic [W:0]   add_a;
	logic [W:0]   add_b;
	logic [W:0]   add_sum;
	logic [W:0]   carry_in;
	logic [W-1:0] closed;
	logic [W-1:0] next_live;

	// Generate is the raw live bit, propagate is a star just below.
	assign add_a    = {1'b0, live_q | prop};
	assign add_b    = {1'b0, live_q};
	assign add_sum  = add_a + add_b;
	assign carry_in = add_sum ^ add_a ^ add_b;
	assign closed   = carry_in[W:1];

	assign next_live = {1'b0, closed[PATTERN_MAX-1:0] & stay}
		| {closed[PATTERN_MAX-1:0] & step, 1'b0};

	assign matched = closed[length];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= W'(1);
		end else if (cmd.restart) begin
			live_q <= W'(1);
		end else if (cmd.advance) begin
			live_q <= next_live;
		end
	end

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the wildcard glob matcher against a bit-vector predictor of its own.
// A short table of directed transactions comes first: empty patterns, a full
// pattern store, stars, question marks, case folding and code unit extremes.
// Random pattern and text sequences follow. The sender idles and the
// receiver stalls in several mixes. Every result is compared field by field
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;

	localparam int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF;
	localparam int RANDOM_ITEMS = 690;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		wgm_pkg::opcode_t           op;
		logic [wgm_pkg::CHAR_W-1:0] ch;
		logic [6:0]                 reps;
		logic                       typed;
		wgm_pkg::result_t           want;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	wgm_pkg::item_t   item;
	logic             result_valid;
	logic             result_ready;
	wgm_pkg::result_t result;

	logic [wgm_pkg::CHAR_W-1:0] pat_chars [PATTERN_MAX];
	int                         pat_len;
	logic [PATTERN_MAX:0]       live;
	logic                       pat_overflow;

	wgm_pkg::result_t expected_results[$];
	dir_row_t         dir_rows[$];
	wgm_pkg::result_t want_now;
	int               idle_pct;
	int               stall_pct;
	int               errors;
	int               items_sent;
	int               results_checked;
	int               matches_seen;
	int               cycles;

	wildcard_glob_matcher dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [wgm_pkg::CHAR_W-1:0] upcase(
			input logic [wgm_pkg::CHAR_W-1:0] c);
		if (c >= 16'h0061 && c <= 16'h007A) begin
			return c - 16'h0020;
		end
		return c;
	endfunction

	function automatic void close_stars();
		for (int i = 0; i < pat_len; i++) begin
			if (live[i] && pat_chars[i] == wgm_pkg::CH_STAR) begin
				live[i+1] = 1'b1;
			end
		end
	endfunction

	function automatic void restart_scan();
		live = '0;
		live[0] = 1'b1;
		close_stars();
	endfunction

	function automatic void scan_char(input logic [wgm_pkg::CHAR_W-1:0] c);
		logic [PATTERN_MAX:0] nxt;
		nxt = '0;
		for (int i = 0; i < pat_len; i++) begin
			if (live[i]) begin
				if (pat_chars[i] == wgm_pkg::CH_STAR) begin
					nxt[i] = 1'b1;
				end else if (pat_chars[i] == wgm_pkg::CH_QUESTION ||
						upcase(pat_chars[i]) == upcase(c)) begin
					nxt[i+1] = 1'b1;
				end
			end
		end
		live = nxt;
		close_stars();
	endfunction

	function automatic bit glob_step(input wgm_pkg::item_t it,
			output wgm_pkg::result_t verdict);
		verdict = '0;
		case (it.opcode)
			wgm_pkg::OP_CLEAR: begin
				pat_len = 0;
				pat_overflow = 1'b0;
				restart_scan();
			end
			wgm_pkg::OP_APPEND: begin
				if (pat_len < PATTERN_MAX) begin
					pat_chars[pat_len] = it.char_code;
					pat_len++;
				end else begin
					pat_overflow = 1'b1;
				end
				restart_scan();
			end
			wgm_pkg::OP_TEXT: begin
				scan_char(it.char_code);
			end
			default: begin
				verdict.matched = live[pat_len];
				verdict.pattern_overflow = pat_overflow;
				restart_scan();
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic dir_row_t row(input wgm_pkg::opcode_t op,
			input logic [wgm_pkg::CHAR_W-1:0] ch,
			input int reps, input logic typed, input logic [1:0] want);
		dir_row_t r;
		r.op = op;
		r.ch = ch;
		r.reps = reps[6:0];
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic logic [wgm_pkg::CHAR_W-1:0] pick_pattern_char();
		case ($urandom_range(9))
			0, 1:    return wgm_pkg::CH_STAR;
			2:       return wgm_pkg::CH_QUESTION;
			3:       return 16'h0061;
			4:       return 16'h0042;
			5:       return 16'h0063;
			6:       return 16'h0041;
			7:       return 16'h0062;
			8:       return 16'($urandom_range(16'h0020, 16'h007E));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [wgm_pkg::CHAR_W-1:0] pick_text_char();
		case ($urandom_range(9))
			0:       return 16'h0061;
			1:       return 16'h0062;
			2:       return 16'h0042;
			3:       return 16'h0043;
			4:       return wgm_pkg::CH_STAR;
			5:       return wgm_pkg::CH_QUESTION;
			6:       return 16'h0000;
			7:       return 16'hFFFF;
			8:       return 16'($urandom_range(16'h0020, 16'h007E));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void note_failure(input string what);
		errors++;
		if (errors <= 10) begin
			$display("[%0t] Mismatch: %s", $realtime, what);
		end
	endfunction

	task automatic send_item(input wgm_pkg::item_t it, input bit typed,
			input wgm_pkg::result_t want);
		wgm_pkg::result_t verdict;
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(negedge clk); while (!item_ready);
		@(posedge clk);
		items_sent++;
		if (glob_step(it, verdict)) begin
			expected_results.push_back(typed ? want : verdict);
		end
	endtask

	task automatic send_plain(input wgm_pkg::opcode_t op,
			input logic [wgm_pkg::CHAR_W-1:0] ch);
		wgm_pkg::item_t it;
		it.opcode = op;
		it.char_code = ch;
		send_item(it, 1'b0, '0);
	endtask

	function automatic void set_mix(input int n);
		if (n < 170) begin
			idle_pct = 0;
			stall_pct = 0;
		end else if (n < 345) begin
			idle_pct = 48;
			stall_pct = 0;
		end else if (n < 520) begin
			idle_pct = 0;
			stall_pct = 48;
		end else begin
			idle_pct = 7;
			stall_pct = 7;
		end
	endfunction

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(negedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				note_failure($sformatf("unexpected result matched=%b overflow=%b",
					result.matched, result.pattern_overflow));
			end else begin
				want_now = expected_results.pop_front();
				results_checked++;
				if (result.matched) begin
					matches_seen++;
				end
				if (result.matched !== want_now.matched ||
						result.pattern_overflow !== want_now.pattern_overflow) begin
					note_failure($sformatf(
						"result %0d matched exp %b got %b, overflow exp %b got %b",
						results_checked, want_now.matched, result.matched,
						want_now.pattern_overflow, result.pattern_overflow));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycles, expected_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		wgm_pkg::item_t             it;
		logic [wgm_pkg::CHAR_W-1:0] pattern[$];
		logic [wgm_pkg::CHAR_W-1:0] text[$];
		logic [wgm_pkg::CHAR_W-1:0] c;
		int                         plen;
		int                         ntexts;
		int                         n_rand;

		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		pat_len = 0;
		pat_overflow = 1'b0;
		restart_scan();

		dir_rows.push_back(row(wgm_pkg::OP_END,    16'h0000,  1, 1'b1, 2'b10));
		dir_rows.push_back(row(wgm_pkg::OP_TEXT,   16'h0078,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_END,    16'h0000,  1, 1'b1, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_APPEND, 16'h0061,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_APPEND, wgm_pkg::CH_STAR, 1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_APPEND, wgm_pkg::CH_QUESTION, 1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_TEXT,   16'h0041,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_TEXT,   wgm_pkg::CH_STAR, 1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_TEXT,   16'h0071,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_TEXT,   16'h007A,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_END,    16'h0000,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_END,    16'h0000,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_CLEAR,  16'h0000,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_APPEND, wgm_pkg::CH_STAR, 2, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_END,    16'h0000,  1, 1'b1, 2'b10));
		dir_rows.push_back(row(wgm_pkg::OP_TEXT,   16'h0000,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_TEXT,   16'hFFFF,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_END,    16'h0000,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_CLEAR,  16'h0000,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_APPEND, 16'h00E9,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_TEXT,   16'h00C9,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_END,    16'h0000,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_CLEAR,  16'h0000,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_APPEND, 16'h0061,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_TEXT,   16'h0061,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_APPEND, 16'h0062,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_TEXT,   16'h0041,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_TEXT,   16'h0042,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_END,    16'h0000,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_CLEAR,  16'h0000,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_APPEND, wgm_pkg::CH_QUESTION, PATTERN_MAX,
			1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_APPEND, 16'hFFFF,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_END,    16'h0000,  1, 1'b1, 2'b01));
		dir_rows.push_back(row(wgm_pkg::OP_TEXT,   16'h006B,  PATTERN_MAX, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_END,    16'h0000,  1, 1'b1, 2'b11));
		dir_rows.push_back(row(wgm_pkg::OP_CLEAR,  16'hFFFF,  1, 1'b0, 2'b00));
		dir_rows.push_back(row(wgm_pkg::OP_END,    16'hFFFF,  1, 1'b1, 2'b10));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			it.opcode = dir_rows[i].op;
			it.char_code = dir_rows[i].ch;
			for (int r = 0; r < dir_rows[i].reps; r++) begin
				send_item(it, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		n_rand = 0;
		while (n_rand < RANDOM_ITEMS) begin
			set_mix(n_rand);
			if ($urandom_range(9) == 0) begin
				send_plain(wgm_pkg::opcode_t'($urandom_range(3)), 16'($urandom));
				n_rand++;
			end else begin
				send_plain(wgm_pkg::OP_CLEAR, 16'($urandom));
				n_rand++;
				pattern.delete();
				if ($urandom_range(24) == 0) begin
					plen = $urandom_range(PATTERN_MAX - 4, PATTERN_MAX + 6);
					ntexts = 1;
				end else begin
					plen = $urandom_range(0, 8);
					ntexts = $urandom_range(1, 4);
				end
				for (int i = 0; i < plen; i++) begin
					c = pick_pattern_char();
					pattern.push_back(c);
					send_plain(wgm_pkg::OP_APPEND, c);
					n_rand++;
				end
				for (int t = 0; t < ntexts; t++) begin
					text.delete();
					if ($urandom_range(3) != 0) begin
						foreach (pattern[i]) begin
							if (i >= PATTERN_MAX) begin
								break;
							end
							if (pattern[i] == wgm_pkg::CH_STAR) begin
								repeat ($urandom_range(0, 3)) text.push_back(pick_text_char());
							end else if (pattern[i] == wgm_pkg::CH_QUESTION) begin
								text.push_back(pick_text_char());
							end else begin
								c = pattern[i];
								if ($urandom_range(1) == 1 &&
										((c >= 16'h0041 && c <= 16'h005A) ||
										(c >= 16'h0061 && c <= 16'h007A))) begin
									c = c ^ 16'h0020;
								end
								text.push_back(c);
							end
						end
						if (text.size() > 0 && $urandom_range(9) == 0) begin
							text[$urandom_range(text.size() - 1)] = pick_text_char();
						end
					end else begin
						repeat ($urandom_range(0, 8)) text.push_back(pick_text_char());
					end
					foreach (text[i]) begin
						send_plain(wgm_pkg::OP_TEXT, text[i]);
						n_rand++;
					end
					send_plain(wgm_pkg::OP_END, 16'($urandom));
					n_rand++;
				end
			end
		end

		item_valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transactions; checked %0d results, %0d of them matches.",
			items_sent, results_checked, matches_seen);
		$display("Covered directed corner cases and random glob sequences under four idle/stall mixes.");
		if (errors == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors, expected_results.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
